// ===== rtl/ising_pkg.sv =====
// ----------------------------------------------------------------------------
// ising_pkg
// Shared codes, field widths and types of the Ising spin update block.
// ----------------------------------------------------------------------------
package ising_pkg;

   localparam int OP_W    = 1;
   localparam int COORD_W = 5;
   localparam int RAND_W  = 16;
   localparam int THR_W   = 16;
   localparam int DE_W    = 5;
   localparam int MAG_W   = 12;
   localparam int MAG_MOD = 4096;

   localparam int CSR_IDX_W = 1;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [RAND_W-1:0]    rand_type;
   typedef logic [THR_W-1:0]     thr_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam op_type OP_UPDATE = 1'b0;
   localparam op_type OP_REINIT = 1'b1;

   localparam csr_index_type CSR_ACCEPT_FOUR  = 1'b0;
   localparam csr_index_type CSR_ACCEPT_EIGHT = 1'b1;

endpackage

// ===== rtl/ising_metropolis_spin_update_top.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_top
// Square spin lattice with wrap-around neighbors, Metropolis single-spin
// updates, reinitialize to all spins up, and a running magnetization.
//
// A request is taken at a rising edge with start high and busy low; it either
// updates one site (row, col, random_fraction) or sets every spin to plus one.
// Its response appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, through the s1_ and rsp_ registers; the receiver cannot stall.
// A new request may be taken every cycle, so throughput is one per cycle.
// The lattice is held in three row-wide copies, one per read port (row above,
// site row, row below); the read data is registered and the previous write is
// forwarded onto it. Reinitialize clears row valid bits. The user must write
// thresholds on the csr_ channel only while no request is in flight; the block
// never checks. Synchronous reset sets all spins up, magnetization to the site
// count, and both thresholds to zero; busy is high for the cycle after reset.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_top
   import ising_pkg::*;
#(
   parameter int LATTICE_SIDE = 32,
   parameter int RANDOM_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    start,
   output logic                    busy,
   input  op_type                  req_op,
   input  coord_type               req_row,
   input  coord_type               req_col,
   input  rand_type                req_random_fraction,

   output logic                    rsp_valid,
   output logic                    rsp_flipped,
   output logic                    rsp_new_spin,
   output logic signed [DE_W-1:0]  rsp_delta_energy,
   output logic signed [MAG_W-1:0] rsp_magnetization,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  csr_index_type           csr_index,
   input  thr_type                 csr_wdata
);

   localparam int IDX_W      = $clog2(LATTICE_SIDE);
   localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
   localparam int RND_W      = (RANDOM_BITS < RAND_W) ? RANDOM_BITS : RAND_W;
   localparam logic [MAG_W-1:0] MAG_INIT = MAG_W'(SITE_COUNT % MAG_MOD);

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [LATTICE_SIDE-1:0] row_type;

   function automatic idx_type wrap_index(input coord_type v);
      logic [8:0] t;
      t = {{(9 - COORD_W){1'b0}}, v};
      for (int i = 0; i < 8; i++) begin
         if (t >= 9'(LATTICE_SIDE)) begin
            t = t - 9'(LATTICE_SIDE);
         end
      end
      return t[IDX_W-1:0];
   endfunction

   function automatic idx_type prev_index(input idx_type v);
      return (v == '0) ? IDX_W'(LATTICE_SIDE - 1) : v - IDX_W'(1);
   endfunction

   function automatic idx_type next_index(input idx_type v);
      return (v == IDX_W'(LATTICE_SIDE - 1)) ? '0 : v + IDX_W'(1);
   endfunction

   row_type mem_up   [LATTICE_SIDE];
   row_type mem_mid  [LATTICE_SIDE];
   row_type mem_down [LATTICE_SIDE];

   row_type          row_valid_ff;
   logic             busy_ff;
   thr_type          thr_four_ff;
   thr_type          thr_eight_ff;
   logic [MAG_W-1:0] mag_ff;
   logic [MAG_W-1:0] mag_in;

   logic             s1_valid_ff;
   op_type           s1_op_ff;
   idx_type          s1_row_ff;
   idx_type          s1_up_ff;
   idx_type          s1_down_ff;
   idx_type          s1_col_ff;
   idx_type          s1_left_ff;
   idx_type          s1_right_ff;
   logic [RND_W-1:0] s1_rnd_ff;
   row_type          rd_up_ff;
   row_type          rd_mid_ff;
   row_type          rd_down_ff;
   logic             vld_up_ff;
   logic             vld_mid_ff;
   logic             vld_down_ff;

   logic             lw_wr_ff;
   logic             lw_init_ff;
   idx_type          lw_row_ff;
   row_type          lw_data_ff;

   logic             rsp_valid_ff;
   logic             rsp_flipped_ff;
   logic             rsp_new_spin_ff;
   logic [DE_W-1:0]  rsp_de_ff;
   logic [MAG_W-1:0] rsp_mag_ff;

   logic             accept;
   idx_type          row0;
   idx_type          col0;
   idx_type          up0;
   idx_type          down0;

   row_type          up_row;
   row_type          mid_row;
   row_type          down_row;
   logic             spin;
   logic [2:0]       up_count;
   logic [2:0]       k;
   logic [DE_W-1:0]  de;
   logic             lt_four;
   logic             lt_eight;
   logic             flip;
   logic             wr_en;
   logic             init_en;
   row_type          wr_data;

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;
   assign accept    = start & ~busy_ff;

   assign row0  = wrap_index(req_row);
   assign col0  = wrap_index(req_col);
   assign up0   = prev_index(row0);
   assign down0 = next_index(row0);

   always_comb begin
      up_row   = vld_up_ff   ? rd_up_ff   : '1;
      mid_row  = vld_mid_ff  ? rd_mid_ff  : '1;
      down_row = vld_down_ff ? rd_down_ff : '1;
      if (lw_init_ff) begin
         up_row   = '1;
         mid_row  = '1;
         down_row = '1;
      end else if (lw_wr_ff) begin
         if (lw_row_ff == s1_up_ff) begin
            up_row = lw_data_ff;
         end
         if (lw_row_ff == s1_row_ff) begin
            mid_row = lw_data_ff;
         end
         if (lw_row_ff == s1_down_ff) begin
            down_row = lw_data_ff;
         end
      end
   end

   always_comb begin
      spin     = mid_row[s1_col_ff];
      up_count = {2'b00, up_row[s1_col_ff]} + {2'b00, down_row[s1_col_ff]}
               + {2'b00, mid_row[s1_left_ff]} + {2'b00, mid_row[s1_right_ff]};
      k        = spin ? up_count : 3'd4 - up_count;
      de       = {k, 2'b00} - DE_W'(8);
      lt_four  = RAND_W'(s1_rnd_ff) < thr_four_ff;
      lt_eight = RAND_W'(s1_rnd_ff) < thr_eight_ff;
      flip     = (k <= 3'd2) | ((k == 3'd3) & lt_four) | ((k == 3'd4) & lt_eight);
      init_en  = s1_valid_ff & (s1_op_ff == OP_REINIT);
      wr_en    = s1_valid_ff & (s1_op_ff == OP_UPDATE) & flip;
      wr_data  = mid_row;
      wr_data[s1_col_ff] = ~spin;
      mag_in   = mag_ff;
      if (init_en) begin
         mag_in = MAG_INIT;
      end else if (wr_en) begin
         mag_in = spin ? mag_ff - MAG_W'(2) : mag_ff + MAG_W'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_up_ff   <= mem_up[up0];
         rd_mid_ff  <= mem_mid[row0];
         rd_down_ff <= mem_down[down0];
      end
      if (wr_en) begin
         mem_up[s1_row_ff]   <= wr_data;
         mem_mid[s1_row_ff]  <= wr_data;
         mem_down[s1_row_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         thr_four_ff  <= '0;
         thr_eight_ff <= '0;
         mag_ff       <= MAG_INIT;
         row_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         lw_wr_ff     <= 1'b0;
         lw_init_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ACCEPT_FOUR:  thr_four_ff  <= csr_wdata;
               CSR_ACCEPT_EIGHT: thr_eight_ff <= csr_wdata;
               default:          thr_four_ff  <= thr_four_ff;
            endcase
         end
         mag_ff <= mag_in;
         if (init_en) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[s1_row_ff] <= 1'b1;
         end
         s1_valid_ff  <= accept;
         lw_wr_ff     <= wr_en;
         lw_init_ff   <= init_en;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_op;
         s1_row_ff   <= row0;
         s1_up_ff    <= up0;
         s1_down_ff  <= down0;
         s1_col_ff   <= col0;
         s1_left_ff  <= prev_index(col0);
         s1_right_ff <= next_index(col0);
         s1_rnd_ff   <= req_random_fraction[RND_W-1:0];
         vld_up_ff   <= row_valid_ff[up0];
         vld_mid_ff  <= row_valid_ff[row0];
         vld_down_ff <= row_valid_ff[down0];
      end
      lw_row_ff  <= s1_row_ff;
      lw_data_ff <= wr_data;
      if (s1_op_ff == OP_REINIT) begin
         rsp_flipped_ff  <= 1'b0;
         rsp_new_spin_ff <= 1'b1;
         rsp_de_ff       <= '0;
      end else begin
         rsp_flipped_ff  <= flip;
         rsp_new_spin_ff <= spin ^ flip;
         rsp_de_ff       <= de;
      end
      rsp_mag_ff <= mag_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flipped       = rsp_flipped_ff;
   assign rsp_new_spin      = rsp_new_spin_ff;
   assign rsp_delta_energy  = $signed(rsp_de_ff);
   assign rsp_magnetization = $signed(rsp_mag_ff);

endmodule

// ===== tb/tb_ising_metropolis_spin_update_top.sv =====
// ----------------------------------------------------------------------------
// tb_ising_metropolis_spin_update_top
// Drives site updates and reinitialize requests into the Ising spin block
// across several threshold settings, predicts every response from a private
// copy of the lattice, and checks each response field by field in order.
// ----------------------------------------------------------------------------
module tb_ising_metropolis_spin_update_top
   import ising_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATTICE_SIDE = 32;
   localparam int RANDOM_BITS  = 16;
   localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 190;

   typedef struct packed {
      op_type    op;
      coord_type row;
      coord_type col;
      rand_type  fraction;
   } spin_request_type;

   typedef struct packed {
      logic                    flipped;
      logic                    new_spin;
      logic signed [DE_W-1:0]  delta_energy;
      logic signed [MAG_W-1:0] magnetization;
   } spin_outcome_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   op_type                  req_op = OP_UPDATE;
   coord_type               req_row = '0;
   coord_type               req_col = '0;
   rand_type                req_random_fraction = '0;
   logic                    rsp_valid;
   logic                    rsp_flipped;
   logic                    rsp_new_spin;
   logic signed [DE_W-1:0]  rsp_delta_energy;
   logic signed [MAG_W-1:0] rsp_magnetization;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_ACCEPT_FOUR;
   thr_type                 csr_wdata = '0;

   spin_request_type queued_requests[$];
   spin_outcome_type pending_spin_results[$];
   spin_request_type live_request;

   bit      spin_up [LATTICE_SIDE][LATTICE_SIDE];
   int      net_spin;
   thr_type thr_four;
   thr_type thr_eight;

   int idle_pct  = 15;
   int idle_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   ising_metropolis_spin_update_top #(
      .LATTICE_SIDE (LATTICE_SIDE),
      .RANDOM_BITS  (RANDOM_BITS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_flipped         (rsp_flipped),
      .rsp_new_spin        (rsp_new_spin),
      .rsp_delta_energy    (rsp_delta_energy),
      .rsp_magnetization   (rsp_magnetization),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void raise_all_spins();
      foreach (spin_up[i, j]) spin_up[i][j] = 1'b1;
      net_spin = SITE_COUNT;
   endfunction

   function automatic int spin_at(int r, int c);
      return spin_up[r][c] ? 1 : -1;
   endfunction

   function automatic spin_outcome_type predict_spin_step(spin_request_type rq);
      spin_outcome_type res;
      int               r;
      int               c;
      int               s;
      int               nsum;
      int               de;
      logic [31:0]      rnd;
      bit               flip;
      if (rq.op == OP_REINIT) begin
         raise_all_spins();
         res.flipped       = 1'b0;
         res.new_spin      = 1'b1;
         res.delta_energy  = '0;
         res.magnetization = net_spin[MAG_W-1:0];
         return res;
      end
      r    = int'(rq.row) % LATTICE_SIDE;
      c    = int'(rq.col) % LATTICE_SIDE;
      rnd  = 32'(rq.fraction) & ((32'd1 << RANDOM_BITS) - 32'd1);
      s    = spin_at(r, c);
      nsum = spin_at((r + LATTICE_SIDE - 1) % LATTICE_SIDE, c)
           + spin_at((r + 1) % LATTICE_SIDE, c)
           + spin_at(r, (c + LATTICE_SIDE - 1) % LATTICE_SIDE)
           + spin_at(r, (c + 1) % LATTICE_SIDE);
      de   = 2 * s * nsum;
      if (de <= 0)
         flip = 1'b1;
      else if (de == 4)
         flip = rnd < 32'(thr_four);
      else
         flip = rnd < 32'(thr_eight);
      if (flip) begin
         spin_up[r][c] = ~spin_up[r][c];
         net_spin      = net_spin - 2 * s;
         s             = -s;
      end
      res.flipped       = flip;
      res.new_spin      = (s > 0);
      res.delta_energy  = de[DE_W-1:0];
      res.magnetization = net_spin[MAG_W-1:0];
      return res;
   endfunction

   task automatic flag_mismatch(string field, int got, int want);
      $display("ERROR %0t ns: %s got %0d expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic add_request(op_type op, int row, int col, int fraction);
      spin_request_type rq;
      rq.op       = op;
      rq.row      = coord_type'(row);
      rq.col      = coord_type'(col);
      rq.fraction = rand_type'(fraction);
      queued_requests.insert(queued_requests.size(), rq);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || start || pending_spin_results.size() != 0);
   endtask

   task automatic write_threshold(csr_index_type idx, thr_type value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ACCEPT_FOUR)
         thr_four = value;
      else
         thr_eight = value;
   endtask

   task automatic load_random_phase(int count, int base_row, int base_col);
      spin_request_type rq;
      repeat (count) begin
         rq.op = ($urandom_range(0, 99) < 3) ? OP_REINIT : OP_UPDATE;
         if ($urandom_range(0, 99) < 60) begin
            rq.row = coord_type'((base_row + $urandom_range(0, 3)) % LATTICE_SIDE);
            rq.col = coord_type'((base_col + $urandom_range(0, 3)) % LATTICE_SIDE);
         end else begin
            rq.row = coord_type'($urandom);
            rq.col = coord_type'($urandom);
         end
         case ($urandom_range(0, 9))
            4, 5:    rq.fraction = rand_type'(thr_four + $urandom_range(0, 4) - 2);
            6, 7:    rq.fraction = rand_type'(thr_eight + $urandom_range(0, 4) - 2);
            8:       rq.fraction = '0;
            9:       rq.fraction = '1;
            default: rq.fraction = rand_type'($urandom);
         endcase
         queued_requests.insert(queued_requests.size(), rq);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy)
            pending_spin_results.insert(pending_spin_results.size(),
                                        predict_spin_step(live_request));
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (queued_requests.size() != 0 && idle_pct != 0
                         && $urandom_range(1, 100) <= idle_pct) begin
               idle_left = $urandom_range(0, 5);
               start <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               live_request = queued_requests.pop_front();
               start               <= 1'b1;
               req_op              <= live_request.op;
               req_row             <= live_request.row;
               req_col             <= live_request.col;
               req_random_fraction <= live_request.fraction;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : response_check
      spin_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_spin_results.size() == 0) begin
            flag_mismatch("response with nothing outstanding", 1, 0);
         end else begin
            want = pending_spin_results.pop_front();
            if (rsp_flipped !== want.flipped)
               flag_mismatch("flipped", rsp_flipped, want.flipped);
            if (rsp_new_spin !== want.new_spin)
               flag_mismatch("new_spin", rsp_new_spin, want.new_spin);
            if (rsp_delta_energy !== want.delta_energy)
               flag_mismatch("delta_energy", $signed(rsp_delta_energy),
                             $signed(want.delta_energy));
            if (rsp_magnetization !== want.magnetization)
               flag_mismatch("magnetization", $signed(rsp_magnetization),
                             $signed(want.magnetization));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ising_metropolis_spin_update_top: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      thr_type four_set  [8];
      thr_type eight_set [8];
      raise_all_spins();
      thr_four  = '0;
      thr_eight = '0;
      four_set  = '{16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'hC000};
      eight_set = '{16'hFFFF, 16'h0000, 16'h2000, 16'h0000,
                    16'hFFFF, 16'h0000, 16'h0000, 16'h4000};
      four_set[5]  = thr_type'($urandom);
      eight_set[5] = thr_type'($urandom);
      four_set[6]  = thr_type'($urandom);
      eight_set[6] = thr_type'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      add_request(OP_UPDATE, 0, 0, 16'h0000);
      add_request(OP_UPDATE, 31, 31, 16'hFFFF);
      add_request(OP_REINIT, 31, 31, 16'hFFFF);
      settle();

      write_threshold(CSR_ACCEPT_FOUR, 16'hFFFF);
      write_threshold(CSR_ACCEPT_EIGHT, 16'hFFFF);
      @(negedge clock);
      add_request(OP_UPDATE, 0, 0, 16'hFFFF);
      add_request(OP_UPDATE, 0, 0, 16'hFFFE);
      add_request(OP_UPDATE, 0, 0, 16'hFFFF);
      add_request(OP_UPDATE, 5, 5, 16'h0000);
      add_request(OP_UPDATE, 5, 6, 16'h0000);
      add_request(OP_UPDATE, 4, 6, 16'h0000);
      add_request(OP_UPDATE, 0, 31, 16'h8000);
      add_request(OP_UPDATE, 31, 0, 16'h7FFF);
      settle();

      write_threshold(CSR_ACCEPT_FOUR, 16'h0000);
      write_threshold(CSR_ACCEPT_EIGHT, 16'h0000);
      @(negedge clock);
      add_request(OP_UPDATE, 4, 5, 16'hFFFF);
      add_request(OP_UPDATE, 31, 0, 16'hFFFF);
      add_request(OP_UPDATE, 5, 7, 16'h0000);
      add_request(OP_UPDATE, 5, 5, 16'h1234);
      add_request(OP_REINIT, 0, 0, 16'h0000);
      settle();

      for (int p = 0; p < 8; p++) begin
         write_threshold(CSR_ACCEPT_FOUR, four_set[p]);
         write_threshold(CSR_ACCEPT_EIGHT, eight_set[p]);
         idle_pct = (p == 3 || p == 7) ? 0 : 15;
         @(negedge clock);
         if (p % 2)
            load_random_phase(PHASE_ITEMS, LATTICE_SIDE - 2, LATTICE_SIDE - 2);
         else
            load_random_phase(PHASE_ITEMS, $urandom_range(0, LATTICE_SIDE - 1),
                              $urandom_range(0, LATTICE_SIDE - 1));
         settle();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("ising_metropolis_spin_update_top: match");
      else
         $display("ising_metropolis_spin_update_top: mismatch");
      $finish;
   end

endmodule
